/* rtl/core/i2cms_pkg.sv */
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared codes and the result record of the I2C master transaction sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

   // item kinds carried on req_tuser
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_POLL  = 2'd2;

   // sequencer phases
   localparam logic [2:0] PH_WAIT  = 3'd0;
   localparam logic [2:0] PH_WRITE = 3'd1;
   localparam logic [2:0] PH_READ  = 3'd2;
   localparam logic [2:0] PH_STOP  = 3'd3;
   localparam logic [2:0] PH_RESET = 3'd4;

   // bus commands
   localparam logic [2:0] CMD_NONE    = 3'd0;
   localparam logic [2:0] CMD_START   = 3'd1;
   localparam logic [2:0] CMD_SEND    = 3'd2;
   localparam logic [2:0] CMD_RESTART = 3'd3;
   localparam logic [2:0] CMD_RX_ACK  = 3'd4;
   localparam logic [2:0] CMD_RX_NACK = 3'd5;
   localparam logic [2:0] CMD_STOP    = 3'd6;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 56;

   typedef struct packed {
      logic        rejected;
      logic        requeue;
      logic        ack_seen;
      logic [15:0] read_count;
      logic        done_res;
      logic [15:0] read_index;
      logic        read_valid;
      logic [7:0]  read_byte;
      logic [7:0]  bus_byte;
      logic [2:0]  command;
   } rsp_type;

endpackage

/* rtl/core/i2cms_wbuf.sv */
// ----------------------------------------------------------------------------
// i2cms_wbuf
// Write byte buffer: one write port, one registered read port, with the
// write forwarded when it hits the entry being read in the same cycle.
// ----------------------------------------------------------------------------
module i2cms_wbuf #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);
   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/i2cms_seq.sv */
// ----------------------------------------------------------------------------
// i2cms_seq
// Transaction state and next-state decision for one accepted item; drives
// the buffer write port and keeps the buffer read aimed at the next byte.
// ----------------------------------------------------------------------------
module i2cms_seq #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_en,
   input  logic [1:0]            op,
   input  logic [7:0]            data_byte,
   input  logic [5:0]            byte_index,
   input  logic [6:0]            dev_addr,
   input  logic [6:0]            write_len_first,
   input  logic [6:0]            write_len_second,
   input  logic [15:0]           read_len,
   input  logic                  flag_ack,
   input  logic                  flag_fault,
   input  logic                  flag_start_done,
   input  logic                  flag_receive,
   input  logic                  flag_other,
   input  logic [7:0]            buf_rd_data,
   output logic                  buf_wr_en,
   output logic [AW-1:0]         buf_wr_addr,
   output logic [AW-1:0]         buf_rd_addr,
   output i2cms_pkg::rsp_type    result
);
   import i2cms_pkg::*;

   localparam int SW = (AW + 1 > 8) ? AW + 1 : 8;

   logic [2:0]  phase_ff, phase_in;
   logic [AW:0] write_pos_ff, write_pos_in;
   logic [6:0]  seg_left_ff, seg_left_in;
   logic [6:0]  second_left_ff, second_left_in;
   logic [15:0] reads_left_ff, reads_left_in;
   logic [15:0] reads_asked_ff, reads_asked_in;
   logic [6:0]  target_addr_ff, target_addr_in;
   logic        got_ack_ff, got_ack_in;

   logic [AW+5:0] idx_wide;
   logic [SW-1:0] len_sum;
   logic [6:0]    second_used;
   logic [15:0]   reads_left_dec;
   logic          no_flag;

   assign idx_wide    = (AW + 6)'(byte_index);
   assign buf_wr_addr = idx_wide[AW-1:0];
   assign buf_wr_en   = item_en && (op == OP_LOAD) && (idx_wide < (AW + 6)'(DEPTH));
   assign buf_rd_addr = write_pos_in[AW-1:0];

   assign second_used    = (write_len_first == 7'd0) ? 7'd0 : write_len_second;
   assign len_sum        = SW'(write_len_first) + SW'(second_used);
   assign reads_left_dec = reads_left_ff - 16'd1;
   assign no_flag = !(flag_ack || flag_fault || flag_start_done || flag_receive
                      || flag_other);

   always_comb begin
      phase_in       = phase_ff;
      write_pos_in   = write_pos_ff;
      seg_left_in    = seg_left_ff;
      second_left_in = second_left_ff;
      reads_left_in  = reads_left_ff;
      reads_asked_in = reads_asked_ff;
      target_addr_in = target_addr_ff;
      got_ack_in     = got_ack_ff;
      result         = '0;

      if (item_en) begin
         case (op)
            OP_START: begin
               if ((phase_ff != PH_WAIT) ||
                   ((write_len_first == 7'd0) && (read_len == 16'd0)) ||
                   (len_sum > SW'(DEPTH))) begin
                  result.rejected = 1'b1;
               end else begin
                  target_addr_in  = dev_addr;
                  write_pos_in    = '0;
                  seg_left_in     = write_len_first;
                  second_left_in  = second_used;
                  reads_left_in   = read_len;
                  reads_asked_in  = read_len;
                  got_ack_in      = 1'b0;
                  result.command  = CMD_START;
                  result.bus_byte = {dev_addr, (write_len_first == 7'd0)};
                  phase_in = (write_len_first == 7'd0) ? PH_READ : PH_WRITE;
               end
            end
            OP_POLL: begin
               case (phase_ff)
                  PH_WRITE: begin
                     if (flag_fault) begin
                        result.command = CMD_STOP;
                        phase_in       = PH_STOP;
                     end else if (flag_ack) begin
                        got_ack_in = 1'b1;
                        if (seg_left_ff != 7'd0) begin
                           result.command  = CMD_SEND;
                           result.bus_byte = buf_rd_data;
                           write_pos_in    = write_pos_ff + (AW + 1)'(1);
                           seg_left_in     = seg_left_ff - 7'd1;
                           // roll into the second segment
                           if ((seg_left_ff == 7'd1) && (second_left_ff != 7'd0)) begin
                              seg_left_in    = second_left_ff;
                              second_left_in = 7'd0;
                           end
                        end else if (reads_left_ff != 16'd0) begin
                           result.command  = CMD_RESTART;
                           result.bus_byte = {target_addr_ff, 1'b1};
                           phase_in        = PH_READ;
                        end else begin
                           result.command = CMD_STOP;
                           phase_in       = PH_STOP;
                        end
                     end else if (no_flag) begin
                        phase_in = PH_RESET;
                     end
                  end
                  PH_READ: begin
                     if (flag_ack) begin
                        if (flag_start_done) begin
                           result.command = CMD_RX_ACK;
                        end
                     end else if (flag_receive) begin
                        if (reads_left_ff != 16'd0) begin
                           result.read_byte  = data_byte;
                           result.read_valid = 1'b1;
                           result.read_index = reads_asked_ff - reads_left_ff;
                           reads_left_in     = reads_left_dec;
                           result.command = (reads_left_dec != 16'd0) ? CMD_RX_ACK
                                                                      : CMD_RX_NACK;
                        end else begin
                           result.command = CMD_RX_NACK;
                        end
                     end else if (flag_fault) begin
                        result.command = CMD_STOP;
                        phase_in       = PH_STOP;
                     end else if (no_flag) begin
                        phase_in = PH_RESET;
                     end
                  end
                  PH_STOP: begin
                     result.done_res   = 1'b1;
                     result.read_count = reads_asked_ff - reads_left_ff;
                     result.ack_seen   = got_ack_ff;
                     phase_in          = PH_WAIT;
                  end
                  PH_RESET: begin
                     result.requeue = 1'b1;
                     phase_in       = PH_WAIT;
                  end
                  default: begin
                     phase_in = PH_WAIT;
                  end
               endcase
            end
            default: begin
               // loads and unused codes leave the sequence alone; an invalid phase returns to wait
               if (phase_ff > PH_RESET) begin
                  phase_in = PH_WAIT;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_WAIT;
         write_pos_ff   <= '0;
         seg_left_ff    <= '0;
         second_left_ff <= '0;
         reads_left_ff  <= '0;
         reads_asked_ff <= '0;
         target_addr_ff <= '0;
         got_ack_ff     <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         write_pos_ff   <= write_pos_in;
         seg_left_ff    <= seg_left_in;
         second_left_ff <= second_left_in;
         reads_left_ff  <= reads_left_in;
         reads_asked_ff <= reads_asked_in;
         target_addr_ff <= target_addr_in;
         got_ack_ff     <= got_ack_in;
      end
   end

endmodule

/* rtl/core/i2c_master_transaction_sequencer.sv */
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer
// Write-then-read I2C master sequencer: buffers write bytes, runs one request
// at a time and turns status polls into bus commands and completion results.
//
//   channel | dir | width     | contents
//   req     | in  | 56 + 2    | load byte, start request or status poll
//   rsp     | out | 56        | bus command, read byte, completion, requeue
//
// One item per cycle while the output register can take it; each item yields
// one result, registered in the output register. The write buffer read is
// kept aimed at the next send position, so sends need not wait for it. Reset
// clears the sequence state; buffer contents are undefined until loaded. A
// stalled result holds the input only while the output register is full.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer #(
   parameter int WRITE_BUF_DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // data_byte, byte_index, dev_addr, write_len_first, write_len_second,
   // read_len, flag_ack, flag_fault, flag_start_done, flag_receive, flag_other
   input  logic [i2cms_pkg::REQ_DATA_W-1:0]      req_tdata,
   // op
   input  logic [1:0]                            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // command, bus_byte, read_byte, read_valid, read_index, done_res,
   // read_count, ack_seen, requeue, rejected
   output logic [i2cms_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import i2cms_pkg::*;

   localparam int AW = (WRITE_BUF_DEPTH > 1) ? $clog2(WRITE_BUF_DEPTH) : 1;

   logic          accept;
   logic          buf_wr_en;
   logic [AW-1:0] buf_wr_addr;
   logic [AW-1:0] buf_rd_addr;
   logic [7:0]    buf_rd_data;
   rsp_type       result;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   i2cms_wbuf #(
      .DEPTH (WRITE_BUF_DEPTH),
      .AW    (AW)
   ) u_wbuf (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_addr (buf_wr_addr),
      .wr_data (req_tdata[7:0]),
      .rd_addr (buf_rd_addr),
      .rd_data (buf_rd_data)
   );

   i2cms_seq #(
      .DEPTH (WRITE_BUF_DEPTH),
      .AW    (AW)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .item_en          (accept),
      .op               (req_tuser),
      .data_byte        (req_tdata[7:0]),
      .byte_index       (req_tdata[13:8]),
      .dev_addr         (req_tdata[20:14]),
      .write_len_first  (req_tdata[27:21]),
      .write_len_second (req_tdata[34:28]),
      .read_len         (req_tdata[50:35]),
      .flag_ack         (req_tdata[51]),
      .flag_fault       (req_tdata[52]),
      .flag_start_done  (req_tdata[53]),
      .flag_receive     (req_tdata[54]),
      .flag_other       (req_tdata[55]),
      .buf_rd_data      (buf_rd_data),
      .buf_wr_en        (buf_wr_en),
      .buf_wr_addr      (buf_wr_addr),
      .buf_rd_addr      (buf_rd_addr),
      .result           (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // hold the result until its transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_ff);

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C master transaction sequencer. A walked table
// covers the corner cases: rejects, lost bus, fault, surplus receive. Random
// request sequences with noise follow. Every accepted item is run through a
// local copy of the sequencer state, and each response transfer is compared
// field by field with the oldest queued response, from the table or predicted.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import i2cms_pkg::*;

   localparam int         BUF_DEPTH    = 64;
   localparam int         RANDOM_ITEMS = 1460;
   localparam logic [1:0] OP_IDLE      = 2'd3;

   // request fields, lowest bits first from the bottom of the list
   typedef struct packed {
      logic        flag_other;
      logic        flag_receive;
      logic        flag_start_done;
      logic        flag_fault;
      logic        flag_ack;
      logic [15:0] read_len;
      logic [6:0]  write_len_second;
      logic [6:0]  write_len_first;
      logic [6:0]  dev_addr;
      logic [5:0]  byte_index;
      logic [7:0]  data_byte;
   } req_item_type;

   typedef struct {
      logic [1:0]   op;
      req_item_type item;
      bit           typed;
      rsp_type      want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // see req_item_type
   logic [1:0]            req_tuser;   // op
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // see rsp_type

   always #10 clock = ~clock;

   i2c_master_transaction_sequencer #(
      .WRITE_BUF_DEPTH(BUF_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   // sequencer state as the bench sees it
   logic [2:0]  seq_phase;
   logic [7:0]  wbuf [BUF_DEPTH];
   logic [6:0]  send_pos;
   logic [6:0]  seg_cnt;
   logic [6:0]  seg2_cnt;
   logic [15:0] reads_todo;
   logic [15:0] reads_total;
   logic [6:0]  addr_q;
   logic        acked;

   rsp_type     bus_results_due[$];
   int          err_count  = 0;
   int          rsp_seen   = 0;
   int          burst_left = 0;

   function automatic rsp_type mk_rsp(logic [2:0] cmd, logic [7:0] bb, logic done,
                                      logic [15:0] cnt, logic ackseen, logic rq,
                                      logic rej);
      rsp_type r;
      r            = '0;
      r.command    = cmd;
      r.bus_byte   = bb;
      r.done_res   = done;
      r.read_count = cnt;
      r.ack_seen   = ackseen;
      r.requeue    = rq;
      r.rejected   = rej;
      return r;
   endfunction

   function automatic req_item_type mk_load(logic [5:0] idx, logic [7:0] b);
      req_item_type it;
      it            = '0;
      it.byte_index = idx;
      it.data_byte  = b;
      return it;
   endfunction

   function automatic req_item_type mk_start(logic [6:0] addr, logic [6:0] w1,
                                             logic [6:0] w2, logic [15:0] rl);
      req_item_type it;
      it                  = '0;
      it.dev_addr         = addr;
      it.write_len_first  = w1;
      it.write_len_second = w2;
      it.read_len         = rl;
      return it;
   endfunction

   function automatic req_item_type mk_poll(logic [7:0] b, logic ack, logic fault,
                                            logic sdone, logic recv, logic other);
      req_item_type it;
      it                 = '0;
      it.data_byte       = b;
      it.flag_ack        = ack;
      it.flag_fault      = fault;
      it.flag_start_done = sdone;
      it.flag_receive    = recv;
      it.flag_other      = other;
      return it;
   endfunction

   // advance the sequencer by one item and return the response it produces
   function automatic rsp_type sequencer_next(logic [1:0] op, req_item_type it);
      rsp_type     r;
      logic [6:0]  w2;
      logic        no_flag;
      int unsigned total;
      r       = '0;
      w2      = it.write_len_second;
      no_flag = !(it.flag_ack || it.flag_fault || it.flag_start_done ||
                  it.flag_receive || it.flag_other);
      if (seq_phase > PH_RESET) seq_phase = PH_WAIT;
      case (op)
         OP_LOAD: begin
            wbuf[it.byte_index] = it.data_byte;
         end
         OP_START: begin
            if (seq_phase != PH_WAIT || (it.write_len_first == 0 && it.read_len == 0)) begin
               r.rejected = 1'b1;
            end else begin
               // no first segment: go straight to reading, drop segment two
               if (it.write_len_first == 0) w2 = '0;
               total = 32'(it.write_len_first) + 32'(w2);
               if (total > BUF_DEPTH) begin
                  r.rejected = 1'b1;
               end else begin
                  addr_q      = it.dev_addr;
                  send_pos    = '0;
                  seg_cnt     = it.write_len_first;
                  seg2_cnt    = w2;
                  reads_todo  = it.read_len;
                  reads_total = it.read_len;
                  acked       = 1'b0;
                  r.command   = CMD_START;
                  r.bus_byte  = {it.dev_addr, it.write_len_first == 0};
                  seq_phase   = (it.write_len_first == 0) ? PH_READ : PH_WRITE;
               end
            end
         end
         OP_POLL: begin
            case (seq_phase)
               PH_WRITE: begin
                  if (it.flag_fault) begin
                     r.command = CMD_STOP;
                     seq_phase = PH_STOP;
                  end else if (it.flag_ack) begin
                     acked = 1'b1;
                     if (seg_cnt != 0) begin
                        r.command  = CMD_SEND;
                        r.bus_byte = wbuf[send_pos[5:0]];
                        send_pos++;
                        seg_cnt--;
                        if (seg_cnt == 0 && seg2_cnt != 0) begin
                           seg_cnt  = seg2_cnt;
                           seg2_cnt = '0;
                        end
                     end else if (reads_todo > 0) begin
                        r.command  = CMD_RESTART;
                        r.bus_byte = {addr_q, 1'b1};
                        seq_phase  = PH_READ;
                     end else begin
                        r.command = CMD_STOP;
                        seq_phase = PH_STOP;
                     end
                  end else if (no_flag) begin
                     seq_phase = PH_RESET;
                  end
               end
               PH_READ: begin
                  if (it.flag_ack) begin
                     if (it.flag_start_done) r.command = CMD_RX_ACK;
                  end else if (it.flag_receive) begin
                     if (reads_todo > 0) begin
                        r.read_byte  = it.data_byte;
                        r.read_valid = 1'b1;
                        r.read_index = reads_total - reads_todo;
                        reads_todo--;
                     end
                     r.command = (reads_todo > 0) ? CMD_RX_ACK : CMD_RX_NACK;
                  end else if (it.flag_fault) begin
                     r.command = CMD_STOP;
                     seq_phase = PH_STOP;
                  end else if (no_flag) begin
                     seq_phase = PH_RESET;
                  end
               end
               PH_STOP: begin
                  r.done_res   = 1'b1;
                  r.read_count = reads_total - reads_todo;
                  r.ack_seen   = acked;
                  seq_phase    = PH_WAIT;
               end
               PH_RESET: begin
                  r.requeue = 1'b1;
                  seq_phase = PH_WAIT;
               end
               default: begin
                  seq_phase = PH_WAIT;
               end
            endcase
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [55:0] got, logic [55:0] want);
      $display("mismatch at response %0d: %s got 0x%0h expected 0x%0h",
               rsp_seen, what, got, want);
      err_count++;
   endtask

   task automatic check_field(string what, logic [55:0] got, logic [55:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   task automatic check_rsp(rsp_type got);
      rsp_type want;
      if (bus_results_due.size() == 0) begin
         report_mismatch("unexpected response", got, '0);
         return;
      end
      want = bus_results_due.pop_front();
      check_field("command", 56'(got.command), 56'(want.command));
      check_field("bus_byte", 56'(got.bus_byte), 56'(want.bus_byte));
      check_field("read_byte", 56'(got.read_byte), 56'(want.read_byte));
      check_field("read_valid", 56'(got.read_valid), 56'(want.read_valid));
      check_field("read_index", 56'(got.read_index), 56'(want.read_index));
      check_field("done_res", 56'(got.done_res), 56'(want.done_res));
      check_field("read_count", 56'(got.read_count), 56'(want.read_count));
      check_field("ack_seen", 56'(got.ack_seen), 56'(want.ack_seen));
      check_field("requeue", 56'(got.requeue), 56'(want.requeue));
      check_field("rejected", 56'(got.rejected), 56'(want.rejected));
   endtask

   // offer one item, hold it until transferred, then update the predictor
   task automatic offer(logic [1:0] op, req_item_type it, bit typed, rsp_type want);
      rsp_type predicted;
      int      gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= it;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = sequencer_next(op, it);
      bus_results_due.push_back(typed ? want : predicted);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // mostly well-formed traffic for the current phase, with some noise
   task automatic pick_random(output logic [1:0] op, output req_item_type it);
      logic [63:0] raw;
      int          roll;
      int          room;
      raw  = {$urandom, $urandom};
      it   = req_item_type'(raw[55:0]);
      roll = $urandom_range(0, 99);
      op   = OP_POLL;
      case (seq_phase)
         PH_WAIT: begin
            if (roll < 70) begin
               op = OP_START;
               if ($urandom_range(0, 9) == 0) begin
                  it.write_len_first = 7'($urandom_range(33, BUF_DEPTH));
               end else begin
                  it.write_len_first = 7'($urandom_range(0, 6));
               end
               room = BUF_DEPTH - int'(it.write_len_first);
               if ($urandom_range(0, 9) == 0) begin
                  it.write_len_second = 7'($urandom_range(0, room));
               end else begin
                  it.write_len_second = 7'($urandom_range(0, (room < 4) ? room : 4));
               end
               if ($urandom_range(0, 19) == 0) it.read_len = 16'($urandom_range(7, 40));
               else it.read_len = 16'($urandom_range(0, 6));
            end else if (roll < 80) begin
               op = OP_LOAD;
            end else if (roll < 90) begin
               op = OP_START;
            end else if (roll >= 96) begin
               op = OP_IDLE;
            end
         end
         PH_WRITE: begin
            if (roll < 80) begin
               it.flag_ack   = 1'b1;
               it.flag_fault = 1'b0;
            end else if (roll < 85) begin
               it.flag_fault = 1'b1;
            end else if (roll < 90) begin
               {it.flag_ack, it.flag_fault, it.flag_start_done, it.flag_receive,
                it.flag_other} = '0;
            end else if (roll < 95) begin
               op = OP_LOAD;
            end else begin
               op = raw[63:62];
            end
         end
         PH_READ: begin
            if (roll < 40) begin
               it.flag_ack     = 1'b0;
               it.flag_receive = 1'b1;
            end else if (roll < 60) begin
               it.flag_ack        = 1'b1;
               it.flag_start_done = 1'b1;
            end else if (roll < 65) begin
               it.flag_ack        = 1'b1;
               it.flag_start_done = 1'b0;
            end else if (roll < 70) begin
               it.flag_ack     = 1'b0;
               it.flag_receive = 1'b0;
               it.flag_fault   = 1'b1;
            end else if (roll < 73) begin
               {it.flag_ack, it.flag_fault, it.flag_start_done, it.flag_receive,
                it.flag_other} = '0;
            end else if (roll < 80) begin
               op = OP_LOAD;
            end else begin
               op = raw[63:62];
            end
         end
         default: begin
            if (roll >= 85) op = raw[63:62];
         end
      endcase
   endtask

   initial begin : stimulus
      stim_row_type rows[$];
      rsp_type      rej;
      logic [1:0]   op;
      req_item_type it;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= '0;
      req_tdata  <= '0;
      seq_phase   = PH_WAIT;
      send_pos    = '0;
      seg_cnt     = '0;
      seg2_cnt    = '0;
      reads_todo  = '0;
      reads_total = '0;
      addr_q      = '0;
      acked       = 1'b0;
      foreach (wbuf[i]) wbuf[i] = '0;
      rej = mk_rsp(CMD_NONE, 8'h00, 1'b0, 16'd0, 1'b0, 1'b0, 1'b1);

      rows.push_back('{OP_POLL, mk_poll(8'hFF, 1, 1, 1, 1, 1), 1, '0});  // idle poll
      rows.push_back('{OP_IDLE, mk_poll(8'hFF, 1, 1, 1, 1, 1), 1, '0});
      rows.push_back('{OP_START, mk_start(7'h7F, 7'd0, 7'd64, 16'd0), 1, rej});  // empty
      rows.push_back('{OP_START, mk_start(7'h7F, 7'd64, 7'd1, 16'hFFFF), 1, rej}); // overflow
      rows.push_back('{OP_LOAD, mk_load(6'd0, 8'hFF), 1, '0});
      rows.push_back('{OP_LOAD, mk_load(6'd63, 8'h00), 1, '0});
      rows.push_back('{OP_LOAD, mk_load(6'd1, 8'hA5), 1, '0});
      rows.push_back('{OP_START, mk_start(7'h7F, 7'd1, 7'd1, 16'd0), 1,
                       mk_rsp(CMD_START, 8'hFE, 0, 16'd0, 0, 0, 0)});
      rows.push_back('{OP_START, mk_start(7'h01, 7'd1, 7'd0, 16'd0), 1, rej});  // busy
      rows.push_back('{OP_POLL, mk_poll(8'h00, 1, 0, 0, 0, 0), 0, '0});
      rows.push_back('{OP_LOAD, mk_load(6'd1, 8'h5A), 1, '0});  // overwrite while busy
      rows.push_back('{OP_POLL, mk_poll(8'h00, 1, 0, 1, 1, 1), 0, '0});
      rows.push_back('{OP_POLL, mk_poll(8'h00, 1, 0, 0, 0, 0), 0, '0});
      rows.push_back('{OP_POLL, mk_poll(8'h00, 0, 0, 0, 0, 0), 1,
                       mk_rsp(CMD_NONE, 8'h00, 1, 16'd0, 1, 0, 0)});
      // read only: segment two is dropped
      rows.push_back('{OP_START, mk_start(7'h00, 7'd0, 7'd5, 16'd2), 1,
                       mk_rsp(CMD_START, 8'h01, 0, 16'd0, 0, 0, 0)});
      rows.push_back('{OP_POLL, mk_poll(8'h00, 1, 0, 1, 0, 0), 0, '0});
      rows.push_back('{OP_POLL, mk_poll(8'h00, 1, 0, 0, 1, 0), 0, '0});
      rows.push_back('{OP_POLL, mk_poll(8'hFF, 0, 1, 0, 1, 0), 0, '0});
      rows.push_back('{OP_POLL, mk_poll(8'h00, 0, 0, 0, 1, 0), 0, '0});
      rows.push_back('{OP_POLL, mk_poll(8'h3C, 0, 0, 0, 1, 0), 0, '0});  // surplus byte
      rows.push_back('{OP_POLL, mk_poll(8'h00, 0, 1, 0, 0, 0), 0, '0});
      rows.push_back('{OP_POLL, mk_poll(8'h00, 0, 0, 0, 0, 0), 1,
                       mk_rsp(CMD_NONE, 8'h00, 1, 16'd2, 0, 0, 0)});
      // lost bus, then requeue
      rows.push_back('{OP_START, mk_start(7'h55, 7'd2, 7'd0, 16'hFFFF), 1,
                       mk_rsp(CMD_START, 8'hAA, 0, 16'd0, 0, 0, 0)});
      rows.push_back('{OP_POLL, mk_poll(8'h00, 0, 0, 0, 0, 0), 0, '0});
      rows.push_back('{OP_POLL, mk_poll(8'h00, 1, 1, 1, 1, 1), 1,
                       mk_rsp(CMD_NONE, 8'h00, 0, 16'd0, 0, 1, 0)});
      // fault while writing
      rows.push_back('{OP_START, mk_start(7'h2A, 7'd1, 7'd0, 16'd0), 1,
                       mk_rsp(CMD_START, 8'h54, 0, 16'd0, 0, 0, 0)});
      rows.push_back('{OP_POLL, mk_poll(8'h00, 1, 1, 0, 0, 0), 0, '0});
      rows.push_back('{OP_POLL, mk_poll(8'h00, 0, 0, 0, 0, 0), 0, '0});

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) offer(rows[i].op, rows[i].item, rows[i].typed, rows[i].want);
      // fill the whole buffer so no send ever reads an unloaded entry
      for (int i = 0; i < BUF_DEPTH; i++) offer(OP_LOAD, mk_load(6'(i), 8'($urandom)), 0, '0);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pick_random(op, it);
         offer(op, it, 0, '0);
      end
      req_tvalid <= 1'b0;

      while (bus_results_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (err_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   initial begin : rsp_side
      int          hold_left;
      int          hold_at;
      int          mode;
      int          cyc;
      logic [15:0] mask;
      logic        ready_next;
      hold_left = 0;
      hold_at   = 250;
      mode      = 0;
      cyc       = 0;
      mask      = 16'hFFFF;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen++;
            check_rsp(rsp_type'(rsp_tdata));
         end
         mask = {mask[14:0], mask[15]};
         if (cyc % 128 == 0) begin
            mode = $urandom_range(0, 3);
            // keep stall runs short in the pattern mode
            mask = 16'($urandom) | 16'h0101;
         end
         cyc++;
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (rsp_seen >= hold_at) begin
            // long hold-off: let the output register fill and back up the input
            hold_left  = 60;
            hold_at   += 700;
            ready_next = 1'b0;
         end else begin
            case (mode)
               0:       ready_next = 1'b1;
               1:       ready_next = 1'($urandom_range(0, 1));
               2:       ready_next = mask[0];
               default: ready_next = ($urandom_range(0, 6) != 0);
            endcase
         end
         rsp_tready <= ready_next;
         @(posedge clock);
      end
   end

   initial begin : watchdog
      #5_000_000;
      $display("tb_top failed");
      $finish;
   end

endmodule
